[hw/rtl/lsacm_pkg.sv]
`default_nettype none
package lsacm_pkg;
	localparam int MAX_SET_BITS_DEF = 6;
	localparam int WAY_SLOTS = 8;
	localparam int WAY_W = 3;
	localparam int RANK_W = 3;
	localparam logic [RANK_W-1:0] RANK_MAX = 3'd7;

	typedef enum logic [1:0] {
		FUNC_LOAD   = 2'd0,
		FUNC_STORE  = 2'd1,
		FUNC_MODIFY = 2'd2,
		FUNC_IGNORE = 2'd3
	} func_t;

	localparam logic [1:0] CFG_SET_BITS = 2'd0;
	localparam logic [1:0] CFG_OFFSET_BITS = 2'd1;
	localparam logic [1:0] CFG_WAYS = 2'd2;

	typedef struct packed {
		logic [1:0]  step_hits;
		logic        step_miss;
		logic        step_eviction;
		logic [31:0] total_hits;
		logic [31:0] total_misses;
		logic [31:0] total_evictions;
	} result_t;

	function automatic logic [31:0] sat_inc(input logic [31:0] v);
		sat_inc = (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
	endfunction
endpackage
`default_nettype wire

[hw/rtl/lsacm_if.sv]
`default_nettype none
interface lsacm_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  func;
	logic [31:0] address;
	modport source (output valid, output func, output address, input ready);
	modport sink (input valid, input func, input address, output ready);
endinterface

interface lsacm_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  step_hits;
	logic        step_miss;
	logic        step_eviction;
	logic [31:0] total_hits;
	logic [31:0] total_misses;
	logic [31:0] total_evictions;
	modport source (output valid, output step_hits, output step_miss, output step_eviction,
		output total_hits, output total_misses, output total_evictions, input ready);
	modport sink (input valid, input step_hits, input step_miss, input step_eviction,
		input total_hits, input total_misses, input total_evictions, output ready);
endinterface
`default_nettype wire

[hw/rtl/lru_set_associative_cache_model_unit.sv]
`default_nettype none
// lru set-associative cache model: each request is one trace access (load, store,
// modify = two accesses, ignored = none) and yields one response with this access's
// hit/miss/eviction flags plus saturating running totals. after reset the line store
// is cleared, one set a cycle, through all 2**MAX_SET_BITS sets before the back end
// starts on requests; the front queue may take up to two requests meanwhile.
// a load or store goes through pop, read row, update and respond; a modify adds a
// second update step on the updated row, and an ignored record only pops and
// responds. the front queue holds two decoded requests so the input keeps flowing
// while the back works. the user must write configuration only while idle; the
// block does not enforce it. registers: 0 set_index_bits, 1 offset_bits, 2 ways.
module lru_set_associative_cache_model_unit #(
	parameter int MAX_SET_BITS = lsacm_pkg::MAX_SET_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	lsacm_req_if.sink        req,
	lsacm_rsp_if.source      rsp,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [4:0]  cfg_data
);
	import lsacm_pkg::*;

	localparam int SET_W = (MAX_SET_BITS < 1) ? 1 : MAX_SET_BITS;

	// configuration registers
	logic [2:0] set_bits_q;
	logic [4:0] offset_bits_q;
	logic [3:0] ways_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_bits_q <= 3'd0;
			offset_bits_q <= 5'd0;
			ways_q <= 4'd1;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SET_BITS:    set_bits_q <= cfg_data[2:0];
				CFG_OFFSET_BITS: offset_bits_q <= cfg_data;
				CFG_WAYS:        ways_q <= cfg_data[3:0];
				default:         ;
			endcase
		end
	end

	// decoded request queue between front and back
	logic             q_valid, q_pop;
	logic [SET_W-1:0] q_set;
	logic [31:0]      q_tag;
	logic [1:0]       q_n;

	lsacm_front #(.MAX_SET_BITS(MAX_SET_BITS), .SET_W(SET_W)) u_front (
		.clk, .arst_n, .req,
		.set_index_bits(set_bits_q), .offset_bits(offset_bits_q),
		.q_valid, .q_pop, .q_set, .q_tag, .q_n
	);

	lsacm_back #(.MAX_SET_BITS(MAX_SET_BITS), .SET_W(SET_W)) u_back (
		.clk, .arst_n, .ways(ways_q),
		.q_valid, .q_pop, .q_set, .q_tag, .q_n, .rsp
	);
endmodule
`default_nettype wire

[hw/rtl/lsacm_front.sv]
`default_nettype none
// decodes the request into set, tag and access count; two-entry queue to the back
module lsacm_front #(
	parameter int MAX_SET_BITS = lsacm_pkg::MAX_SET_BITS_DEF,
	parameter int SET_W = (MAX_SET_BITS < 1) ? 1 : MAX_SET_BITS
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	lsacm_req_if.sink             req,
	input  wire logic [2:0]       set_index_bits,
	input  wire logic [4:0]       offset_bits,
	output logic                  q_valid,
	input  wire logic             q_pop,
	output logic [SET_W-1:0]      q_set,
	output logic [31:0]           q_tag,
	output logic [1:0]            q_n
);
	import lsacm_pkg::*;

	logic [SET_W-1:0] set_q [2];
	logic [31:0]      tag_q [2];
	logic [1:0]       n_q [2];
	logic             rd_q, wr_q;
	logic [1:0]       cnt_q;
	logic [5:0]       sb, shift;
	logic [31:0]      shifted, set_full, tag_d;
	logic [1:0]       n_d;

	always_comb begin
		sb = (int'(set_index_bits) > MAX_SET_BITS) ? 6'(MAX_SET_BITS) : {3'd0, set_index_bits};
		shifted = req.address >> offset_bits;
		set_full = shifted & ((32'd1 << sb) - 32'd1);
		shift = sb + {1'b0, offset_bits};
		tag_d = (shift >= 6'd32) ? 32'd0 : (req.address >> shift);
		case (req.func)
			FUNC_MODIFY: n_d = 2'd2;
			FUNC_IGNORE: n_d = 2'd0;
			default:     n_d = 2'd1;
		endcase
	end

	assign req.ready = (cnt_q != 2'd2);
	assign q_valid = (cnt_q != 2'd0);
	assign q_set = set_q[rd_q];
	assign q_tag = tag_q[rd_q];
	assign q_n = n_q[rd_q];

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			set_q[wr_q] <= set_full[SET_W-1:0];
			tag_q[wr_q] <= tag_d;
			n_q[wr_q] <= n_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q <= 1'b0;
			wr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (req.valid && req.ready) wr_q <= ~wr_q;
			if (q_pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(req.valid && req.ready) - 2'(q_pop);
		end
	end
endmodule
`default_nettype wire

[hw/rtl/lsacm_back.sv]
`default_nettype none
// per-item sequencer: clear the line store after reset, then read set row, compare and update, repeat for modify
module lsacm_back #(
	parameter int MAX_SET_BITS = lsacm_pkg::MAX_SET_BITS_DEF,
	parameter int SET_W = (MAX_SET_BITS < 1) ? 1 : MAX_SET_BITS
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic [3:0]       ways,
	input  wire logic             q_valid,
	output logic                  q_pop,
	input  wire logic [SET_W-1:0] q_set,
	input  wire logic [31:0]      q_tag,
	input  wire logic [1:0]       q_n,
	lsacm_rsp_if.source           rsp
);
	import lsacm_pkg::*;

	localparam int SETS = 1 << MAX_SET_BITS;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_CLEAR = 5'b00010,
		ST_READ  = 5'b00100,
		ST_EXEC  = 5'b01000,
		ST_OUT   = 5'b10000
	} state_t;

	typedef struct packed {
		logic             valid;
		logic [RANK_W-1:0] rank;
		logic [31:0]      tag;
	} line_t;

	line_t mem [SETS][WAY_SLOTS];
	line_t row_q [WAY_SLOTS];
	line_t row_d [WAY_SLOTS];

	state_t            state_q;
	logic [SET_W-1:0]  clr_q;
	logic [SET_W-1:0]  set_q;
	logic [31:0]       tag_q;
	logic [1:0]        left_q;
	logic              first_q;
	result_t           res_q;
	logic [3:0]        nw;
	logic              hit;
	logic [WAY_W-1:0]  hit_w, free_w, vic_w, tgt_w;
	logic              has_free, evict;
	logic [RANK_W-1:0] best, limit;
	logic              wr_en;
	logic [SET_W-1:0]  wr_set;

	always_comb begin
		nw = (ways == 4'd0) ? 4'd1 : ((ways > 4'd8) ? 4'd8 : ways);
		hit = 1'b0; hit_w = '0; has_free = 1'b0; free_w = '0;
		vic_w = '0; best = '0;
		for (int i = WAY_SLOTS - 1; i >= 0; i--) begin
			if (4'(i) < nw) begin
				if (row_q[i].valid && row_q[i].tag == tag_q) begin
					hit = 1'b1; hit_w = WAY_W'(i);
				end
				if (!row_q[i].valid) begin
					has_free = 1'b1; free_w = WAY_W'(i);
				end
			end
		end
		for (int i = 0; i < WAY_SLOTS; i++) begin
			if (4'(i) < nw && row_q[i].valid && (row_q[i].rank > best || i == 0 ||
				!row_q[vic_w].valid)) begin
				if (!row_q[vic_w].valid || 4'(vic_w) >= nw || row_q[i].rank > best ||
					(i == 0)) begin
					best = row_q[i].rank; vic_w = WAY_W'(i);
				end
			end
		end
		evict = !hit && !has_free;
		tgt_w = hit ? hit_w : (has_free ? free_w : vic_w);
		limit = hit ? row_q[hit_w].rank : RANK_MAX;
		for (int i = 0; i < WAY_SLOTS; i++) begin
			row_d[i] = row_q[i];
			if (4'(i) < nw && WAY_W'(i) != tgt_w && row_q[i].valid &&
				(!hit || row_q[i].rank < limit) && row_q[i].rank != RANK_MAX)
				row_d[i].rank = row_q[i].rank + 1'b1;
		end
		row_d[tgt_w].rank = '0;
		row_d[tgt_w].valid = 1'b1;
		row_d[tgt_w].tag = tag_q;
	end

	assign wr_en = (state_q == ST_CLEAR) || (state_q == ST_EXEC);
	assign wr_set = (state_q == ST_CLEAR) ? clr_q : set_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			for (int i = 0; i < WAY_SLOTS; i++) begin
				if (state_q == ST_CLEAR) mem[wr_set][i].valid <= 1'b0;
				else mem[wr_set][i] <= row_d[i];
			end
		end
		if (state_q == ST_EXEC) row_q <= row_d;
		else row_q <= mem[set_q];
	end

	assign q_pop = (state_q == ST_IDLE) && q_valid;
	assign rsp.valid = (state_q == ST_OUT);
	assign rsp.step_hits = res_q.step_hits;
	assign rsp.step_miss = res_q.step_miss;
	assign rsp.step_eviction = res_q.step_eviction;
	assign rsp.total_hits = res_q.total_hits;
	assign rsp.total_misses = res_q.total_misses;
	assign rsp.total_evictions = res_q.total_evictions;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q <= '0;
			set_q <= '0;
			tag_q <= '0;
			left_q <= '0;
			first_q <= 1'b0;
			res_q <= '0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (int'(clr_q) == SETS - 1) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (q_valid) begin
						set_q <= q_set;
						tag_q <= q_tag;
						left_q <= q_n;
						first_q <= 1'b1;
						res_q.step_hits <= '0;
						res_q.step_miss <= 1'b0;
						res_q.step_eviction <= 1'b0;
						state_q <= (q_n == 2'd0) ? ST_OUT : ST_READ;
					end
				end
				ST_READ: state_q <= ST_EXEC;
				ST_EXEC: begin
					first_q <= 1'b0;
					left_q <= left_q - 1'b1;
					if (hit) begin
						res_q.step_hits <= res_q.step_hits + 1'b1;
						res_q.total_hits <= sat_inc(res_q.total_hits);
					end else begin
						if (first_q) res_q.step_miss <= 1'b1;
						res_q.total_misses <= sat_inc(res_q.total_misses);
					end
					if (evict) begin
						res_q.step_eviction <= 1'b1;
						res_q.total_evictions <= sat_inc(res_q.total_evictions);
					end
					if (left_q == 2'd1) state_q <= ST_OUT;
				end
				ST_OUT: if (rsp.ready) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

[bench/lsacm_tb_if.sv]
`timescale 1ns / 1ps
// the block's own interfaces (lsacm_req_if, lsacm_rsp_if) live in the rtl tree;
// this file holds the bench-side wrapper for the configuration port
interface lsacm_cfg_tb_if (input logic clk);
	logic       we;
	logic [1:0] index;
	logic [4:0] data;
	modport source (output we, output index, output data);
	modport sink (input we, input index, input data);
endinterface

[bench/lsacm_checker.sv]
`timescale 1ns / 1ps
module lsacm_checker
	import lsacm_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	lsacm_req_if      req,
	lsacm_rsp_if      rsp,
	lsacm_cfg_tb_if   cfg,
	output int        fail_count,
	output int        pending
);
	logic [2:0]  sb_bits;
	logic [4:0]  ob_bits;
	logic [3:0]  way_cfg;
	logic        valid_q [512];
	logic [31:0] tag_q [512];
	logic [2:0]  rank_q [512];
	logic [31:0] hit_sum, miss_sum, evict_sum;
	result_t     outcome_q [$];

	assign pending = outcome_q.size();

	function automatic logic [31:0] bump(input logic [31:0] v);
		return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
	endfunction

	task automatic age_lines(input int base, input int nw, input int w, input int lim);
		for (int i = 0; i < nw; i++)
			if (i != w && valid_q[base + i] && int'(rank_q[base + i]) < lim &&
				rank_q[base + i] < 3'd7)
				rank_q[base + i] = rank_q[base + i] + 3'd1;
		rank_q[base + w] = 3'd0;
	endtask

	task automatic probe(input logic [31:0] addr, output bit hit, output bit evicted);
		int sb, ob, nw, base, fw, victim, best;
		logic [31:0] tag;
		sb = (int'(sb_bits) > MAX_SET_BITS_DEF) ? MAX_SET_BITS_DEF : int'(sb_bits);
		ob = int'(ob_bits);
		nw = (way_cfg == 4'd0) ? 1 : (way_cfg > 4'd8 ? 8 : int'(way_cfg));
		base = int'((addr >> ob) & ((32'd1 << sb) - 32'd1)) * 8;
		tag = (sb + ob >= 32) ? 32'd0 : addr >> (sb + ob);
		hit = 1'b0;
		evicted = 1'b0;
		for (int i = 0; i < nw; i++)
			if (valid_q[base + i] && tag_q[base + i] == tag) begin
				age_lines(base, nw, i, int'(rank_q[base + i]));
				hit = 1'b1;
				return;
			end
		fw = 8;
		victim = 0;
		best = -1;
		for (int i = 0; i < nw; i++) begin
			if (!valid_q[base + i]) begin
				if (fw == 8) fw = i;
			end else if (int'(rank_q[base + i]) > best) begin
				best = int'(rank_q[base + i]);
				victim = i;
			end
		end
		if (fw == 8) begin
			evicted = 1'b1;
			fw = victim;
		end
		valid_q[base + fw] = 1'b1;
		tag_q[base + fw] = tag;
		age_lines(base, nw, fw, 8);
	endtask

	task automatic predict(input func_t f, input logic [31:0] addr);
		result_t r;
		int n;
		bit h, e;
		r = '0;
		n = (f == FUNC_MODIFY) ? 2 : (f == FUNC_IGNORE ? 0 : 1);
		for (int k = 0; k < n; k++) begin
			probe(addr, h, e);
			if (h) begin
				r.step_hits = r.step_hits + 2'd1;
				hit_sum = bump(hit_sum);
			end else begin
				if (k == 0) r.step_miss = 1'b1;
				miss_sum = bump(miss_sum);
			end
			if (e) begin
				r.step_eviction = 1'b1;
				evict_sum = bump(evict_sum);
			end
		end
		r.total_hits = hit_sum;
		r.total_misses = miss_sum;
		r.total_evictions = evict_sum;
		outcome_q.push_back(r);
	endtask

	task automatic compare(input string name, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t w;
		if (!arst_n) begin
			sb_bits <= 3'd0;
			ob_bits <= 5'd0;
			way_cfg <= 4'd1;
			hit_sum = 32'd0;
			miss_sum = 32'd0;
			evict_sum = 32'd0;
			fail_count = 0;
			outcome_q.delete();
			for (int i = 0; i < 512; i++) begin
				valid_q[i] = 1'b0;
				tag_q[i] = 32'd0;
				rank_q[i] = 3'd0;
			end
		end else begin
			if (cfg.we) begin
				case (cfg.index)
					CFG_SET_BITS: sb_bits <= cfg.data[2:0];
					CFG_OFFSET_BITS: ob_bits <= cfg.data;
					CFG_WAYS: way_cfg <= cfg.data[3:0];
					default: ;
				endcase
			end
			if (req.valid && req.ready) predict(func_t'(req.func), req.address);
			if (rsp.valid && rsp.ready) begin
				if (outcome_q.size() == 0) begin
					$error("response with no request outstanding");
					fail_count++;
				end else begin
					w = outcome_q.pop_front();
					compare("step_hits", 32'(w.step_hits), 32'(rsp.step_hits));
					compare("step_miss", 32'(w.step_miss), 32'(rsp.step_miss));
					compare("step_eviction", 32'(w.step_eviction),
						32'(rsp.step_eviction));
					compare("total_hits", w.total_hits, rsp.total_hits);
					compare("total_misses", w.total_misses, rsp.total_misses);
					compare("total_evictions", w.total_evictions, rsp.total_evictions);
				end
			end
		end
	end
endmodule

[bench/lru_set_associative_cache_model_unit_tb.sv]
`timescale 1ns / 1ps
module lru_set_associative_cache_model_unit_tb;
	import lsacm_pkg::*;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   pending;
	int   cycle_count;
	bit   hold_rsp;     // long receiver hold-off, raised by the stimulus process
	bit   stim_done;

	lsacm_req_if    req ();
	lsacm_rsp_if    rsp ();
	lsacm_cfg_tb_if cfg (.clk(clk));

	lru_set_associative_cache_model_unit dut (
		.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp),
		.cfg_we(cfg.we), .cfg_index(cfg.index), .cfg_data(cfg.data)
	);

	lsacm_checker chk (
		.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp), .cfg(cfg),
		.fail_count(fail_count), .pending(pending)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// a few tags per set so that hits and evictions both happen often
	logic [31:0] addr_pool [16];

	// send one request, with a random gap in front of it
	task automatic send(input func_t f, input logic [31:0] a);
		int gap;
		gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.func <= f;
		req.address <= a;
		do @(posedge clk); while (!req.ready);
	endtask

	task automatic set_reg(input logic [1:0] idx, input logic [4:0] val);
		cfg.we <= 1'b1;
		cfg.index <= idx;
		cfg.data <= val;
		@(posedge clk);
		cfg.we <= 1'b0;
		@(posedge clk);
	endtask

	// wait until every expected response has come
	task automatic drain();
		req.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	// drain, then let the back end settle before touching configuration
	task automatic quiesce();
		drain();
		repeat (12) @(posedge clk);
	endtask

	// reuse a small pool of addresses so sets fill and lines get hit
	function automatic logic [31:0] pick_addr();
		logic [31:0] a;
		a = addr_pool[$urandom_range(0, 15)];
		if ($urandom_range(0, 7) == 0) a = $urandom();
		else a ^= $urandom_range(0, 3);  // offset noise keeps the same line when offset_bits is at least 2
		return a;
	endfunction

	function automatic func_t pick_func();
		return func_t'($urandom_range(0, 3));
	endfunction

	// receiver: random stalls, plus the long hold-off when asked
	initial begin
		int stall;
		rsp.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
			if (hold_rsp) stall = 300;
			if (stall > 0) begin
				rsp.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp.ready <= 1'b1;
			do @(posedge clk); while (!rsp.valid);
		end
	end

	// phase settings: set bits, offset bits, ways; extremes included
	initial begin
		logic [4:0] phase_cfg [6][3];
		phase_cfg = '{'{0, 0, 1}, '{6, 4, 8}, '{7, 31, 0}, '{2, 2, 2},
			'{3, 28, 15}, '{1, 0, 4}};
		req.valid <= 1'b0;
		req.func <= FUNC_LOAD;
		req.address <= '0;
		cfg.we <= 1'b0;
		cfg.index <= CFG_SET_BITS;
		cfg.data <= '0;
		hold_rsp = 0;
		stim_done = 0;
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: field extremes, every access kind, ignored records,
		// modify hit after fill, unknown register index
		set_reg(2'd3, 5'h1f);
		send(FUNC_LOAD, 32'h0);
		send(FUNC_LOAD, 32'h0);
		send(FUNC_STORE, 32'hFFFF_FFFF);
		send(FUNC_MODIFY, 32'hAAAA_AAAA);
		send(FUNC_MODIFY, 32'h5555_5555);
		send(FUNC_IGNORE, 32'h1234_5678);
		send(FUNC_LOAD, 32'h5555_5555);
		send(FUNC_STORE, 32'h8000_0000);
		send(FUNC_IGNORE, 32'hFFFF_FFFF);
		quiesce();

		for (int p = 0; p < 6; p++) begin
			set_reg(CFG_SET_BITS, phase_cfg[p][0]);
			set_reg(CFG_OFFSET_BITS, phase_cfg[p][1]);
			set_reg(CFG_WAYS, phase_cfg[p][2]);
			for (int i = 0; i < 16; i++) addr_pool[i] = $urandom();
			if (p == 1) begin
				// fill the block while nothing drains
				hold_rsp = 1;
				for (int i = 0; i < 20; i++) send(pick_func(), pick_addr());
				hold_rsp = 0;
			end
			for (int i = 0; i < 300; i++) begin
				send(pick_func(), pick_addr());
				if (i == 150) drain();
			end
			quiesce();
		end
		stim_done = 1;
	end

	// cycle watchdog and final verdict
	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > 400000) begin
				$display("lru_set_associative_cache_model_unit_tb: done, errors");
				$finish;
			end else if (stim_done && pending == 0) begin
				repeat (20) @(posedge clk);
				if (fail_count == 0 && pending == 0)
					$display("lru_set_associative_cache_model_unit_tb: done, clean");
				else
					$display("lru_set_associative_cache_model_unit_tb: done, errors");
				$finish;
			end
		end
	end
endmodule
